// ===== design/wccs_pkg.sv =====
// Shared types, constants and helpers of the wiper clean cycle sequencer.
`default_nettype none
package wccs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN  = 3'd1,
    PH_PUMP  = 3'd2,
    PH_UP    = 3'd3,
    PH_TOP   = 3'd4,
    PH_REST  = 3'd5,
    PH_STALL = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_STALL_TIMEOUT = 3'd0,
    REG_PUMP_DURATION = 3'd1,
    REG_TOP_PAUSE     = 3'd2,
    REG_SLOW_WINDOW   = 3'd3,
    REG_DEBOUNCE      = 3'd4,
    REG_DOWN_SPEED    = 3'd5,
    REG_UP_SPEED      = 3'd6,
    REG_SLOW_SPEED    = 3'd7
  } reg_e;

  localparam logic signed [1:0] DIR_UP   = 2'sb01;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;
  localparam logic signed [1:0] DIR_OFF  = 2'sb00;

  localparam logic [31:0] RST_STALL_TIMEOUT = 32'd30000;
  localparam logic [31:0] RST_PUMP_DURATION = 32'd5000;
  localparam logic [31:0] RST_TOP_PAUSE     = 32'd3000;
  localparam logic [31:0] RST_SLOW_WINDOW   = 32'd3000;
  localparam logic [7:0]  RST_DEBOUNCE      = 8'd5;
  localparam logic [7:0]  RST_DOWN_SPEED    = 8'd155;
  localparam logic [7:0]  RST_UP_SPEED      = 8'd255;
  localparam logic [7:0]  RST_SLOW_SPEED    = 8'd55;

  localparam logic [7:0]  CNT_MAX = 8'd255;

  typedef struct packed {
    logic [31:0] stall_timeout;
    logic [31:0] pump_duration;
    logic [31:0] top_pause;
    logic [31:0] slow_window;
    logic [7:0]  debounce;
    logic [7:0]  down_speed;
    logic [7:0]  up_speed;
    logic [7:0]  slow_speed;
  } cfg_t;

  typedef struct packed {
    logic [7:0] count;
    logic       latched;
    logic       accept;
  } deb_t;

  // Saturating high-poll counter with latch; accept flags a new acceptance.
  function automatic deb_t debounce(input logic level, input logic [7:0] count,
                                    input logic latched, input logic [7:0] polls);
    deb_t r;
    r.count   = count;
    r.latched = latched;
    r.accept  = 1'b0;
    if (level) begin
      if (count != CNT_MAX) r.count = count + 8'd1;
      if ((r.count >= polls) && !latched) begin
        r.latched = 1'b1;
        r.accept  = 1'b1;
      end
    end else begin
      r.count   = 8'd0;
      r.latched = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/wiper_clean_cycle_sequencer_unit.sv =====
// Wiper clean cycle sequencer: input register, sequencing logic, result register.
// Each item passes two register stages, the input register and the result register.
// Throughput: one item per cycle while the result is taken; the phase and debounce
// update is one 32-bit subtract and its compares per item, so back-to-back items see fresh state.
// Reset: asynchronous, active low; phase idle, motor off, counters and latches
// cleared, configuration registers back to their defaults.
`default_nettype none
module wiper_clean_cycle_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // now_ms[31:0], bottom_switch[32], top_switch[33]
  input  wire logic [1:0]  s_axis_tuser_i,  // op[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // motor_direction[1:0], motor_speed[9:2],
                                            // phase[12:10], start_ignored[13]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  wccs_pkg::cfg_t cfg;

  wccs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input stage
  logic           in_valid_q;
  wccs_pkg::op_e  op_q;
  logic [31:0]    now_q;
  logic           bot_q, top_q;
  logic           adv, in_acc;

  assign adv             = in_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= wccs_pkg::op_e'(s_axis_tuser_i);
      now_q <= s_axis_tdata_i[31:0];
      bot_q <= s_axis_tdata_i[32];
      top_q <= s_axis_tdata_i[33];
    end
  end

  // sequencer state
  wccs_pkg::phase_e  phase_q, phase_d;
  logic [31:0]       start_q, start_d;
  logic [7:0]        bcnt_q, bcnt_d, tcnt_q, tcnt_d;
  logic              blat_q, blat_d, tlat_q, tlat_d;
  logic signed [1:0] dir_q, dir_d;
  logic [7:0]        spd_q, spd_d;
  logic              ign_d;

  logic [31:0]   elapsed;
  logic          stall_hit;
  wccs_pkg::deb_t bdeb, tdeb;

  assign elapsed   = now_q - start_q;
  assign stall_hit = elapsed > cfg.stall_timeout;
  assign bdeb      = wccs_pkg::debounce(bot_q, bcnt_q, blat_q, cfg.debounce);
  assign tdeb      = wccs_pkg::debounce(top_q, tcnt_q, tlat_q, cfg.debounce);

  // next state
  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    bcnt_d  = bcnt_q;
    tcnt_d  = tcnt_q;
    blat_d  = blat_q;
    tlat_d  = tlat_q;
    case (op_q)
      wccs_pkg::OP_POLL: begin
        case (phase_q)
          wccs_pkg::PH_DOWN: begin
            if (stall_hit) begin
              phase_d = wccs_pkg::PH_STALL;
              start_d = now_q;
            end else begin
              bcnt_d = bdeb.count;
              blat_d = bdeb.latched;
              if (bdeb.accept) begin
                phase_d = wccs_pkg::PH_PUMP;
                start_d = now_q;
              end
            end
          end
          wccs_pkg::PH_PUMP: begin
            if (elapsed >= cfg.pump_duration) begin
              phase_d = wccs_pkg::PH_UP;
              start_d = now_q;
            end
          end
          wccs_pkg::PH_UP: begin
            if (stall_hit) begin
              phase_d = wccs_pkg::PH_STALL;
              start_d = now_q;
            end else begin
              tcnt_d = tdeb.count;
              tlat_d = tdeb.latched;
              if (tdeb.accept) begin
                phase_d = wccs_pkg::PH_TOP;
                start_d = now_q;
              end
            end
          end
          wccs_pkg::PH_TOP: begin
            if (elapsed >= cfg.top_pause) begin
              phase_d = wccs_pkg::PH_REST;
              start_d = now_q;
            end
          end
          wccs_pkg::PH_REST: begin
            if (stall_hit) begin
              phase_d = wccs_pkg::PH_STALL;
              start_d = now_q;
            end else if (bdeb.accept) begin
              // back at rest: clear all debounce state
              phase_d = wccs_pkg::PH_IDLE;
              start_d = now_q;
              bcnt_d  = 8'd0;
              tcnt_d  = 8'd0;
              blat_d  = 1'b0;
              tlat_d  = 1'b0;
            end else begin
              bcnt_d = bdeb.count;
              blat_d = bdeb.latched;
            end
          end
          default: ;
        endcase
      end
      wccs_pkg::OP_START: begin
        if (phase_q == wccs_pkg::PH_IDLE) begin
          phase_d = bot_q ? wccs_pkg::PH_PUMP : wccs_pkg::PH_DOWN;
          start_d = now_q;
        end
      end
      wccs_pkg::OP_STOP: phase_d = wccs_pkg::PH_IDLE;
      default: ;
    endcase
  end

  // drive outputs
  always_comb begin
    dir_d = dir_q;
    spd_d = spd_q;
    ign_d = 1'b0;
    case (op_q)
      wccs_pkg::OP_POLL: begin
        if (phase_d != phase_q) begin
          case (phase_d)
            wccs_pkg::PH_UP: begin
              dir_d = wccs_pkg::DIR_UP;
              spd_d = cfg.up_speed;
            end
            wccs_pkg::PH_REST: begin
              dir_d = wccs_pkg::DIR_DOWN;
              spd_d = cfg.slow_speed;
            end
            default: begin
              dir_d = wccs_pkg::DIR_OFF;
              spd_d = 8'd0;
            end
          endcase
        end else if (phase_q == wccs_pkg::PH_REST) begin
          dir_d = wccs_pkg::DIR_DOWN;
          spd_d = (elapsed <= cfg.slow_window) ? cfg.slow_speed : cfg.down_speed;
        end
      end
      wccs_pkg::OP_START: begin
        if (phase_q != wccs_pkg::PH_IDLE) begin
          ign_d = 1'b1;
        end else if (phase_d == wccs_pkg::PH_DOWN) begin
          dir_d = wccs_pkg::DIR_DOWN;
          spd_d = cfg.down_speed;
        end
      end
      wccs_pkg::OP_STOP: begin
        dir_d = wccs_pkg::DIR_OFF;
        spd_d = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wccs_pkg::PH_IDLE;
      start_q <= 32'd0;
      bcnt_q  <= 8'd0;
      tcnt_q  <= 8'd0;
      blat_q  <= 1'b0;
      tlat_q  <= 1'b0;
      dir_q   <= wccs_pkg::DIR_OFF;
      spd_q   <= 8'd0;
    end else if (adv) begin
      phase_q <= phase_d;
      start_q <= start_d;
      bcnt_q  <= bcnt_d;
      tcnt_q  <= tcnt_d;
      blat_q  <= blat_d;
      tlat_q  <= tlat_d;
      dir_q   <= dir_d;
      spd_q   <= spd_d;
    end
  end

  // result stage
  logic        out_valid_q;
  logic [15:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {2'b00, ign_d, phase_d, spd_d, dir_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// ===== design/wccs_cfg.sv =====
// Configuration register file of the wiper clean cycle sequencer.
`default_nettype none
module wccs_cfg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  output wccs_pkg::cfg_t           cfg_o
);

  wccs_pkg::cfg_t cfg_q, cfg_d;
  wccs_pkg::reg_e idx;

  assign cfg_ready_o = 1'b1;
  assign idx         = wccs_pkg::reg_e'(cfg_index_i);
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (idx)
        wccs_pkg::REG_STALL_TIMEOUT: cfg_d.stall_timeout = cfg_data_i;
        wccs_pkg::REG_PUMP_DURATION: cfg_d.pump_duration = cfg_data_i;
        wccs_pkg::REG_TOP_PAUSE:     cfg_d.top_pause     = cfg_data_i;
        wccs_pkg::REG_SLOW_WINDOW:   cfg_d.slow_window   = cfg_data_i;
        wccs_pkg::REG_DEBOUNCE:      cfg_d.debounce      = cfg_data_i[7:0];
        wccs_pkg::REG_DOWN_SPEED:    cfg_d.down_speed    = cfg_data_i[7:0];
        wccs_pkg::REG_UP_SPEED:      cfg_d.up_speed      = cfg_data_i[7:0];
        wccs_pkg::REG_SLOW_SPEED:    cfg_d.slow_speed    = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_timeout <= wccs_pkg::RST_STALL_TIMEOUT;
      cfg_q.pump_duration <= wccs_pkg::RST_PUMP_DURATION;
      cfg_q.top_pause     <= wccs_pkg::RST_TOP_PAUSE;
      cfg_q.slow_window   <= wccs_pkg::RST_SLOW_WINDOW;
      cfg_q.debounce      <= wccs_pkg::RST_DEBOUNCE;
      cfg_q.down_speed    <= wccs_pkg::RST_DOWN_SPEED;
      cfg_q.up_speed      <= wccs_pkg::RST_UP_SPEED;
      cfg_q.slow_speed    <= wccs_pkg::RST_SLOW_SPEED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire
